[src/binary_gcd_64_top_macros.svh]
// Assertion macros used by the binary GCD back end.
`ifndef BINARY_GCD_64_TOP_MACROS_SVH
`define BINARY_GCD_64_TOP_MACROS_SVH

// Same-cycle implication.
`define BGCD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bgcd_pkg.sv]
// Package: shared types, constants and helpers of the binary GCD block.
package bgcd_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int STRIP_BITS  = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMMON,
		ST_RUN,
		ST_DONE
	} back_state_t;

	// Trailing zeros of one byte; STRIP_BITS when the byte is zero.
	function automatic logic [3:0] tz8(input logic [STRIP_BITS-1:0] x);
		logic [3:0] n;
		n = 4'(STRIP_BITS);
		for (int i = STRIP_BITS - 1; i >= 0; i--) begin
			if (x[i]) begin
				n = 4'(i);
			end
		end
		return n;
	endfunction

endpackage

[src/bgcd_if.sv]
// Channel interfaces: operand pair in, GCD result out.
interface bgcd_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] operand_a;
	logic [63:0] operand_b;

	modport source(output valid, output operand_a, output operand_b, input ready);
	modport sink(input valid, input operand_a, input operand_b, output ready);
endinterface

interface bgcd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] gcd_value;

	modport source(output valid, output gcd_value, input ready);
	modport sink(input valid, input gcd_value, output ready);
endinterface

[src/bgcd_fifo.sv]
// Short queue between the front end and the back end.
module bgcd_fifo #(
	parameter int W     = 129,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

[src/bgcd_front.sv]
// Front end: accepts operand pairs, masks them and flags zero-operand cases.
module bgcd_front #(
	parameter int WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bgcd_in_if.sink              operands,
	output logic                 push_valid,
	input  logic                 push_ready,
	output logic [2*WIDTH:0]     push_data
);
	logic             v_s1;
	logic             direct_s1;
	logic [WIDTH-1:0] a_s1;
	logic [WIDTH-1:0] b_s1;
	logic [WIDTH-1:0] ma;
	logic [WIDTH-1:0] mb;
	logic             accept;

	assign ma         = operands.operand_a[WIDTH-1:0];
	assign mb         = operands.operand_b[WIDTH-1:0];
	assign operands.ready = !v_s1 || push_ready;
	assign accept     = operands.valid && operands.ready;
	assign push_valid = v_s1;
	assign push_data  = {direct_s1, a_s1, b_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// Zero operand: the other operand is the answer, carried in the a field.
	always_ff @(posedge clk) begin
		if (accept) begin
			direct_s1 <= (ma == '0) || (mb == '0);
			a_s1      <= (ma == '0) ? mb : ma;
			b_s1      <= mb;
		end
	end
endmodule

[src/bgcd_back.sv]
// Back end: common-factor strip, subtract-and-strip loop (skipped for zero-operand answers), result register.
`include "binary_gcd_64_top_macros.svh"

module bgcd_back #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  logic [2*WIDTH:0] pop_data,
	bgcd_out_if.source       result
);
	import bgcd_pkg::*;

	localparam int KW = $clog2(WIDTH);

	back_state_t      state_q;
	back_state_t      state_n;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [KW-1:0]    k_q;
	logic             direct_q;
	logic [WIDTH-1:0] a_n;
	logic [WIDTH-1:0] b_n;
	logic [KW-1:0]    k_n;
	logic             direct_n;
	logic             res_valid_q;
	logic [WIDTH-1:0] res_q;
	logic             out_free;
	logic             load_res;
	logic [WIDTH-1:0] or_v;
	logic [3:0]       sh_c;
	logic [3:0]       sh_a;
	logic [3:0]       sh_b;
	logic             both_odd;
	logic             a_gt_b;
	logic [WIDTH-1:0] diff;

	assign out_free = !res_valid_q || result.ready;
	assign or_v     = a_q | b_q;
	assign sh_c     = tz8(or_v[STRIP_BITS-1:0]);
	assign sh_a     = a_q[0] ? 4'd0 : tz8(a_q[STRIP_BITS-1:0]);
	assign sh_b     = b_q[0] ? 4'd0 : tz8(b_q[STRIP_BITS-1:0]);
	assign both_odd = a_q[0] && b_q[0];
	assign a_gt_b   = a_q > b_q;
	assign diff     = a_gt_b ? (a_q - b_q) : (b_q - a_q);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					state_n = pop_data[2*WIDTH] ? ST_DONE : ST_COMMON;
				end
			end
			ST_COMMON: begin
				if (or_v[0]) begin
					state_n = ST_RUN;
				end
			end
			ST_RUN: begin
				if (both_odd && a_q == b_q) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		load_res  = 1'b0;
		a_n       = a_q;
		b_n       = b_q;
		k_n       = k_q;
		direct_n  = direct_q;
		case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					direct_n = pop_data[2*WIDTH];
					a_n      = pop_data[2*WIDTH-1:WIDTH];
					b_n      = pop_data[WIDTH-1:0];
					k_n      = '0;
				end
			end
			ST_COMMON: begin
				if (!or_v[0]) begin
					a_n = a_q >> sh_c;
					b_n = b_q >> sh_c;
					k_n = KW'({1'b0, k_q} + (KW + 1)'(sh_c));
				end
			end
			ST_RUN: begin
				if (!both_odd) begin
					a_n = a_q >> sh_a;
					b_n = b_q >> sh_b;
				end else if (a_q != b_q) begin
					a_n = diff;
					b_n = a_gt_b ? b_q : a_q;
				end
			end
			ST_DONE: begin
				load_res = out_free;
			end
			default: begin
				pop_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_q      <= a_n;
		b_q      <= b_n;
		k_q      <= k_n;
		direct_q <= direct_n;
		if (load_res) begin
			res_q <= a_q << k_q;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.gcd_value = 64'(res_q);

	`BGCD_ASSERT_IMPL(operands_nonzero_chk, clk, arst_n, state_q == ST_COMMON || state_q == ST_RUN, a_q != '0 && b_q != '0, "operand reached zero during reduction")
	`BGCD_ASSERT_IMPL(done_converged_chk, clk, arst_n, state_q == ST_DONE && !direct_q, a_q[0] && a_q == b_q, "reduction finished without odd equal operands")
	`BGCD_ASSERT_NEXT(subtract_stays_chk, clk, arst_n, state_q == ST_RUN && both_odd && a_q != b_q, state_q == ST_RUN && !a_q[0], "subtract round left run state or gave odd difference")
endmodule

[src/binary_gcd_64_top.sv]
// Top level of the binary GCD block: front end, queue and back end.
// An operand pair is taken by the front register, waits in a two-entry queue and is reduced
// by the back end one item at a time. If either operand is zero the item goes from the
// idle state straight to the done state. Otherwise the back end first strips common trailing
// zeros, up to eight per step, until an operand is odd, then loops: each cycle either strips
// up to eight trailing zeros from the operands or does one compare-and-subtract; the loop runs
// until the operands are equal, and the result leaves through an output register that lets
// the next item start meanwhile.
module binary_gcd_64_top #(
	parameter int WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	bgcd_in_if.sink     operands,
	bgcd_out_if.source  result
);
	import bgcd_pkg::*;

	localparam int IW = 2 * WIDTH + 1;

	logic          f_valid;
	logic          f_ready;
	logic [IW-1:0] f_data;
	logic          b_valid;
	logic          b_ready;
	logic [IW-1:0] b_data;

	bgcd_front #(.WIDTH(WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.operands   (operands),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data)
	);

	bgcd_fifo #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	bgcd_back #(.WIDTH(WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data),
		.result    (result)
	);
endmodule
